>>> sv/png_row_unfilter_unit_assert.svh
// Assertion macros for the PNG row unfilter unit.
// Included by the top level; needs nothing else.
`ifndef PNG_ROW_UNFILTER_UNIT_ASSERT_SVH
`define PNG_ROW_UNFILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("png row unfilter: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("png row unfilter: assertion failed");

`endif

>>> sv/pru_pkg.sv
// Shared types and constants for the PNG row unfilter unit.
// Depends on nothing; the front end, queue, back end and top level use it.
`default_nettype none

package pru_pkg;

   localparam int MAX_ROW_BYTES = 8192;
   localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
   localparam int POS_W = $clog2(MAX_ROW_BYTES + 1);
   localparam int CFG_W = 14;
   localparam int BPP_W = 3;
   localparam int MAX_BPP = 4;
   localparam int HIST_DEPTH = 4;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic CSR_ROW_LENGTH = 1'b0;
   localparam logic CSR_PIXEL_BYTES = 1'b1;

   typedef enum logic [2:0] {
      FILT_NONE = 3'd0,
      FILT_SUB = 3'd1,
      FILT_UP = 3'd2,
      FILT_AVERAGE = 3'd3,
      FILT_PAETH = 3'd4
   } pru_filter_type;

   localparam logic [7:0] FILT_MAX = 8'd4;

   typedef struct packed {
      logic bad;
      logic [7:0] raw;
      pru_filter_type filter;
      logic [ADDR_W-1:0] x;
      logic first;
      logic last;
   } pru_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } pru_queue_status_type;

endpackage

`default_nettype wire

>>> sv/pru_if.sv
// Handshake channel interfaces for the PNG row unfilter unit.
// Uses nothing outside this file.
`default_nettype none

interface pru_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic image_start;
   modport source (output valid, output data_byte, output image_start, input ready);
   modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

interface pru_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] pixel_value;
   logic row_end;
   logic bad_filter;
   modport source (output valid, output pixel_value, output row_end, output bad_filter,
                   input ready);
   modport sink (input valid, input pixel_value, input row_end, input bad_filter,
                 output ready);
endinterface

`default_nettype wire

>>> sv/pru_front.sv
// Front end: tracks row position, filter type and error dropping per item.
// Depends on pru_pkg.
`default_nettype none

module pru_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic [7:0] data_byte,
   input  wire logic image_start,
   input  wire logic [pru_pkg::POS_W-1:0] row_len,
   output pru_pkg::pru_entry_type entry,
   output logic push
);

   logic [pru_pkg::POS_W-1:0] pos_ff, pos_in, pos_eff;
   pru_pkg::pru_filter_type filter_ff, filter_in;
   logic first_ff, first_in, first_eff;
   logic drop_ff, drop_in, drop_eff;

   always_comb begin
      pos_eff = image_start ? '0 : pos_ff;
      first_eff = image_start ? 1'b1 : first_ff;
      drop_eff = image_start ? 1'b0 : drop_ff;
      pos_in = pos_ff;
      filter_in = filter_ff;
      first_in = first_ff;
      drop_in = drop_ff;
      push = 1'b0;
      entry = '0;
      entry.filter = filter_ff;
      entry.raw = data_byte;
      entry.x = pru_pkg::ADDR_W'(pos_eff - pru_pkg::POS_W'(1));
      entry.first = first_eff;
      entry.last = (pos_eff >= row_len);
      if (accept) begin
         pos_in = pos_eff;
         first_in = first_eff;
         drop_in = drop_eff;
         if (!drop_eff) begin
            if (pos_eff == '0) begin
               if (data_byte > pru_pkg::FILT_MAX) begin
                  drop_in = 1'b1;
                  filter_in = pru_pkg::FILT_NONE;
                  push = 1'b1;
                  entry.bad = 1'b1;
               end else begin
                  filter_in = pru_pkg::pru_filter_type'(data_byte[2:0]);
                  pos_in = pru_pkg::POS_W'(1);
               end
            end else begin
               push = 1'b1;
               if (pos_eff >= row_len) begin
                  pos_in = '0;
                  first_in = 1'b0;
               end else begin
                  pos_in = pos_eff + pru_pkg::POS_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         filter_ff <= pru_pkg::FILT_NONE;
         first_ff <= 1'b1;
         drop_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         filter_ff <= filter_in;
         first_ff <= first_in;
         drop_ff <= drop_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/pru_queue.sv
// Short item queue between the front end and the reconstruction back end.
// Depends on pru_pkg.
`default_nettype none

module pru_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire pru_pkg::pru_entry_type push_entry,
   input  wire logic pop,
   output pru_pkg::pru_entry_type head,
   output pru_pkg::pru_queue_status_type status
);

   pru_pkg::pru_entry_type slots_ff [pru_pkg::Q_DEPTH];
   logic [pru_pkg::Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [pru_pkg::Q_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full = (count_ff == pru_pkg::Q_CNT_W'(pru_pkg::Q_DEPTH));
      head = slots_ff[rd_ptr_ff];
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + pru_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pru_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + pru_pkg::Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + pru_pkg::Q_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> sv/pru_back.sv
// Back end: line store, neighbour histories, filter reconstruction and result register.
// Depends on pru_pkg and the result channel interface in pru_if.sv.
`default_nettype none

module pru_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire pru_pkg::pru_entry_type head,
   input  wire logic head_valid,
   input  wire logic [pru_pkg::BPP_W-1:0] bpp,
   output logic pop,
   output logic stage_valid,
   pru_rsp_if.source rsp
);

   logic [7:0] line_mem [pru_pkg::MAX_ROW_BYTES];

   pru_pkg::pru_entry_type stage_ff;
   logic stage_valid_ff;
   logic [7:0] rd_ff;
   logic fwd_ff;
   logic [7:0] fwd_val_ff;

   logic [7:0] left_ff [pru_pkg::HIST_DEPTH];
   logic [7:0] upleft_ff [pru_pkg::HIST_DEPTH];

   logic out_valid_ff;
   logic [7:0] out_pixel_ff;
   logic out_row_end_ff;
   logic out_bad_ff;

   logic fire, mem_write, has_left;
   logic [1:0] hist_sel;
   logic [7:0] left, up, upleft, pred, value;
   logic [8:0] avg_sum;

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [9:0] sa, sb, sc, da, db, dc;
      logic [7:0] res;
      sa = signed'({2'b00, a});
      sb = signed'({2'b00, b});
      sc = signed'({2'b00, c});
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) begin
         res = a;
      end else if (db <= dc) begin
         res = b;
      end else begin
         res = c;
      end
      return res;
   endfunction

   always_comb begin
      fire = stage_valid_ff && (!out_valid_ff || rsp.ready);
      pop = head_valid && (!stage_valid_ff || fire);
      mem_write = fire && !stage_ff.bad;
      has_left = ({{(pru_pkg::ADDR_W-pru_pkg::BPP_W){1'b0}}, bpp} <= stage_ff.x);
      hist_sel = 2'(bpp - pru_pkg::BPP_W'(1));
      left = has_left ? left_ff[hist_sel] : 8'd0;
      up = stage_ff.first ? 8'd0 : (fwd_ff ? fwd_val_ff : rd_ff);
      upleft = (has_left && !stage_ff.first) ? upleft_ff[hist_sel] : 8'd0;
      avg_sum = {1'b0, left} + {1'b0, up};
      case (stage_ff.filter)
         pru_pkg::FILT_NONE: pred = 8'd0;
         pru_pkg::FILT_SUB: pred = left;
         pru_pkg::FILT_UP: pred = up;
         pru_pkg::FILT_AVERAGE: pred = avg_sum[8:1];
         pru_pkg::FILT_PAETH: pred = paeth(left, up, upleft);
         default: pred = 8'd0;
      endcase
      value = stage_ff.raw + pred;
      stage_valid = stage_valid_ff;
      rsp.valid = out_valid_ff;
      rsp.pixel_value = out_pixel_ff;
      rsp.row_end = out_row_end_ff;
      rsp.bad_filter = out_bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < pru_pkg::HIST_DEPTH; i++) begin
            left_ff[i] <= 8'd0;
            upleft_ff[i] <= 8'd0;
         end
      end else begin
         if (pop) begin
            stage_valid_ff <= 1'b1;
         end else if (fire) begin
            stage_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (mem_write) begin
            for (int i = pru_pkg::HIST_DEPTH - 1; i > 0; i--) begin
               left_ff[i] <= left_ff[i-1];
               upleft_ff[i] <= upleft_ff[i-1];
            end
            left_ff[0] <= value;
            upleft_ff[0] <= up;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         stage_ff <= head;
         fwd_ff <= mem_write && (stage_ff.x == head.x);
         fwd_val_ff <= value;
      end
      if (fire) begin
         out_pixel_ff <= stage_ff.bad ? 8'd0 : value;
         out_row_end_ff <= stage_ff.last && !stage_ff.bad;
         out_bad_ff <= stage_ff.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_write) begin
         line_mem[stage_ff.x] <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= line_mem[head.x];
      end
   end

endmodule

`default_nettype wire

>>> sv/png_row_unfilter_unit.sv
// Top level of the PNG row unfilter unit: configuration registers and the three parts.
// Depends on pru_pkg, pru_if.sv, pru_front, pru_queue, pru_back and the assertion header.
`default_nettype none

// Reconstructs PNG filtered rows from the inflated byte stream. One byte is accepted per
// clock cycle while the queue is not full, and one result leaves per cycle while the
// result channel is ready; the back end updates its left-neighbour history from each byte
// just rebuilt. An accepted data byte goes into the queue, then into the stage register
// with its line-store read, then through reconstruction into the result register. Valid
// filter-type bytes and dropped bytes give no result; an invalid filter-type byte gives a
// bad_filter result. The previous row lives in an 8192-byte line store with one read and
// one write port that needs no clearing after reset. Row length and pixel bytes may only
// be written while no item is in flight.

`include "png_row_unfilter_unit_assert.svh"

module png_row_unfilter_unit (
   input  wire logic clock,
   input  wire logic reset,
   pru_req_if.sink req,
   pru_rsp_if.source rsp,
   input  wire logic csr_write_en,
   input  wire logic csr_index,
   input  wire logic [pru_pkg::CFG_W-1:0] csr_wdata
);

   logic [pru_pkg::CFG_W-1:0] row_length_ff;
   logic [pru_pkg::BPP_W-1:0] pixel_bytes_ff;
   logic [pru_pkg::POS_W-1:0] row_len;
   logic [pru_pkg::BPP_W-1:0] bpp;

   logic accept, push, pop, stage_valid;
   pru_pkg::pru_entry_type push_entry, head;
   pru_pkg::pru_queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= pru_pkg::CFG_W'(1);
         pixel_bytes_ff <= pru_pkg::BPP_W'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            pru_pkg::CSR_ROW_LENGTH: row_length_ff <= csr_wdata;
            pru_pkg::CSR_PIXEL_BYTES: pixel_bytes_ff <= csr_wdata[pru_pkg::BPP_W-1:0];
            default: row_length_ff <= row_length_ff;
         endcase
      end
   end

   always_comb begin
      if (row_length_ff == '0) begin
         row_len = pru_pkg::POS_W'(1);
      end else if (row_length_ff > pru_pkg::CFG_W'(pru_pkg::MAX_ROW_BYTES)) begin
         row_len = pru_pkg::POS_W'(pru_pkg::MAX_ROW_BYTES);
      end else begin
         row_len = pru_pkg::POS_W'(row_length_ff);
      end
      if (pixel_bytes_ff == '0) begin
         bpp = pru_pkg::BPP_W'(1);
      end else if (pixel_bytes_ff > pru_pkg::BPP_W'(pru_pkg::MAX_BPP)) begin
         bpp = pru_pkg::BPP_W'(pru_pkg::MAX_BPP);
      end else begin
         bpp = pixel_bytes_ff;
      end
      req.ready = !q_status.full;
      accept = req.valid && !q_status.full;
   end

   pru_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .data_byte(req.data_byte),
      .image_start(req.image_start),
      .row_len(row_len),
      .entry(push_entry),
      .push(push)
   );

   pru_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .head(head),
      .status(q_status)
   );

   pru_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .head_valid(!q_status.empty),
      .bpp(bpp),
      .pop(pop),
      .stage_valid(stage_valid),
      .rsp(rsp)
   );

   `PRU_ASSERT_SAME(a_no_overflow, clock, reset, push, !q_status.full || pop)
   `PRU_ASSERT_SAME(a_error_format, clock, reset, rsp.valid && rsp.bad_filter, !rsp.row_end && rsp.pixel_value == 8'd0)
   `PRU_ASSERT_NEXT(a_stage_fills, clock, reset, !q_status.empty && !stage_valid, stage_valid)

endmodule

`default_nettype wire
